// ----- src/nlv_pkg.sv -----
// Shared types, character codes and the infinity-word lookup for the literal validator.
`timescale 1ns / 1ps
package nlv_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [1:0] INF_LEN = 2'd3;

  typedef struct packed {
    logic       rejected;
    logic       digit_seen;
    logic       point_seen;
    logic       exponent_seen;
    logic       exponent_digit_seen;
    logic       word_mode;
    logic [1:0] word_matched;
    logic       word_mismatch;
  } nlv_state_t;

  localparam nlv_state_t NLV_STATE_RESET = '0;

  function automatic logic [7:0] inf_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = CH_I;
      2'd1:    c = CH_N;
      2'd2:    c = CH_F;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

// ----- src/nlv_channels.sv -----
// Handshake channels: character beats in, verdict beats out.
`timescale 1ns / 1ps
interface nlv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last;

  modport source (output valid, output byte_in, output last, input ready);
  modport sink   (input valid, input byte_in, input last, output ready);
endinterface

interface nlv_verdict_if;
  logic valid;
  logic ready;
  logic valid_res;

  modport source (output valid, output valid_res, input ready);
  modport sink   (input valid, input valid_res, output ready);
endinterface

// ----- src/numeric_literal_validator_unit.sv -----
// Top level of the numeric literal validator: input register, flag state, verdict register.
//
// Usage:
//   chars   : one character per beat (byte_in), last marks the final character.
//   verdict : one beat per string, valid_res = 1 when the whole string is a
//             decimal number (signs, digits, one point, optional e/E exponent)
//             or optional signs followed by "inf". Any byte of 0x80 or above
//             rejects the string.
//   Path    : a final character is accepted into the input register and its
//             verdict is then presented from the verdict register.
//   Rate    : one character per cycle unless a held verdict blocks a final character;
//             the flag update is a few gates between input and state/verdict registers.
//   Stall   : a held verdict blocks only a final character behind it; other
//             characters keep flowing. chars.ready falls while the input
//             register holds a final character and the verdict register is
//             full and not being taken.
//   Reset   : rst (synchronous, active high) empties both registers and
//             clears all string flags; chars.ready is low during reset and
//             rises as soon as rst is released.
`timescale 1ns / 1ps
module numeric_literal_validator_unit (
  input  logic          clk,
  input  logic          rst,
  nlv_byte_if.sink      chars,
  nlv_verdict_if.source verdict
);
  import nlv_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_ch;
  logic       s1_last;
  nlv_state_t state;
  nlv_state_t state_next;
  logic       ok;
  logic       o_valid;
  logic       o_res;
  logic       fire;

  nlv_step u_step (
    .state      (state),
    .ch         (s1_ch),
    .last       (s1_last),
    .state_next (state_next),
    .ok         (ok)
  );

  assign fire         = s1_valid && (!s1_last || !o_valid || verdict.ready);
  assign chars.ready  = !rst && (!s1_valid || fire);
  assign verdict.valid     = o_valid;
  assign verdict.valid_res = o_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      s1_ch   <= chars.byte_in;
      s1_last <= chars.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= NLV_STATE_RESET;
    end else if (fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (fire && s1_last) begin
      o_valid <= 1'b1;
    end else if (verdict.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_last) begin
      o_res <= ok;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    fire && s1_last |=> state == NLV_STATE_RESET)
    else $error("flags not cleared after final character");

  a_reject_sticks: assert property (@(posedge clk) disable iff (rst)
    fire && !s1_last && state.rejected |=> state.rejected)
    else $error("rejection dropped inside a string");

  a_high_byte_fails: assert property (@(posedge clk) disable iff (rst)
    fire && s1_last && s1_ch[7] |=> o_valid && !o_res)
    else $error("high byte on final character did not fail the string");

  a_word_no_digits: assert property (@(posedge clk) disable iff (rst)
    state.word_mode |-> !state.digit_seen)
    else $error("word mode entered after a mantissa digit");

  a_no_verdict_overrun: assert property (@(posedge clk) disable iff (rst)
    o_valid && !verdict.ready |=> o_valid && $stable(o_res))
    else $error("held verdict overwritten");
`endif

endmodule

// ----- src/nlv_step.sv -----
// Per-character flag update and end-of-string verdict.
`timescale 1ns / 1ps
module nlv_step (
  input  nlv_pkg::nlv_state_t state,
  input  logic [7:0]          ch,
  input  logic                last,
  output nlv_pkg::nlv_state_t state_next,
  output logic                ok
);
  import nlv_pkg::*;

  nlv_state_t upd;
  logic       is_sign;
  logic       is_e;
  logic       is_digit;
  logic       word_hit;

  assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
  assign is_e     = (ch == CH_E_LO) || (ch == CH_E_UP);
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign word_hit = (state.word_matched < INF_LEN) && (ch == inf_char(state.word_matched));

  always_comb begin
    upd = state;
    if (ch[7]) begin
      upd.rejected = 1'b1;
    end else if (!state.rejected) begin
      if (state.word_mode) begin
        if (ch == CH_MINUS) begin
          upd.rejected = 1'b1;
        end else if (word_hit) begin
          upd.word_matched = state.word_matched + 2'd1;
        end else begin
          upd.word_mismatch = 1'b1;
        end
      end else if (is_sign) begin
        if (!state.exponent_seen) begin
          if (state.digit_seen || state.point_seen) upd.rejected = 1'b1;
        end else if (state.exponent_digit_seen) begin
          upd.rejected = 1'b1;
        end
      end else if (is_e && state.digit_seen) begin
        if (!state.exponent_seen) upd.exponent_seen = 1'b1;
        else                      upd.rejected      = 1'b1;
      end else if (ch == CH_POINT) begin
        if (state.exponent_seen || state.point_seen) upd.rejected   = 1'b1;
        else                                         upd.point_seen = 1'b1;
      end else if (is_digit) begin
        if (!state.exponent_seen) upd.digit_seen          = 1'b1;
        else                      upd.exponent_digit_seen = 1'b1;
      end else if (!is_e && (state.digit_seen || state.point_seen)) begin
        upd.rejected = 1'b1;
      end else begin
        // first character of a word
        upd.word_mode = 1'b1;
        if (word_hit) upd.word_matched  = state.word_matched + 2'd1;
        else          upd.word_mismatch = 1'b1;
      end
    end
  end

  always_comb begin
    priority if (upd.rejected) begin
      ok = 1'b0;
    end else if (upd.word_mode) begin
      ok = !upd.word_mismatch && (upd.word_matched == INF_LEN);
    end else begin
      ok = upd.digit_seen && (!upd.exponent_seen || upd.exponent_digit_seen);
    end
  end

  assign state_next = last ? NLV_STATE_RESET : upd;

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the numeric literal validator: random strings, handshake stalls.
`timescale 1ns / 1ps
module testbench;
  import nlv_pkg::*;

  localparam int BYTE_TARGET   = 950;
  localparam int QUIET_TAIL    = 120;
  localparam int LONG_HOLD     = 400;
  localparam int IDLE_LIMIT    = 5000;
  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       drain;
  } char_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nlv_byte_if    chars_ch ();
  nlv_verdict_if verdict_ch ();

  numeric_literal_validator_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_ch),
    .verdict (verdict_ch)
  );

  always #2 clk = ~clk;

  char_beat_t  char_feed[$];
  logic        verdict_due[$];
  nlv_state_t  lit_state = NLV_STATE_RESET;
  logic [7:0]  inf_text[3] = '{CH_I, CH_N, CH_F};
  int          mismatches = 0;
  int          verdicts_seen = 0;

  // ---------------------------------------------------------------- predictor
  function automatic void match_inf(input logic [7:0] c);
    if (lit_state.word_matched < INF_LEN && c == inf_text[lit_state.word_matched])
      lit_state.word_matched = lit_state.word_matched + 2'd1;
    else
      lit_state.word_mismatch = 1'b1;
  endfunction

  function automatic void scan_char(input logic [7:0] c, input logic fin,
                                    output logic has_verdict, output logic verdict);
    has_verdict = 1'b0;
    verdict = 1'b0;
    if (c[7]) begin
      lit_state.rejected = 1'b1;
    end else if (!lit_state.rejected) begin
      if (lit_state.word_mode) begin
        if (c == CH_MINUS) lit_state.rejected = 1'b1;
        else match_inf(c);
      end else if (c == CH_PLUS || c == CH_MINUS) begin
        if (!lit_state.exponent_seen) begin
          if (lit_state.digit_seen || lit_state.point_seen) lit_state.rejected = 1'b1;
        end else if (lit_state.exponent_digit_seen) begin
          lit_state.rejected = 1'b1;
        end
      end else if (c == CH_E_LO || c == CH_E_UP) begin
        if (!lit_state.digit_seen) begin
          lit_state.word_mode = 1'b1;
          match_inf(c);
        end else if (!lit_state.exponent_seen) begin
          lit_state.exponent_seen = 1'b1;
        end else begin
          lit_state.rejected = 1'b1;
        end
      end else if (c == CH_POINT) begin
        if (lit_state.exponent_seen || lit_state.point_seen) lit_state.rejected = 1'b1;
        else lit_state.point_seen = 1'b1;
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        if (!lit_state.exponent_seen) lit_state.digit_seen = 1'b1;
        else lit_state.exponent_digit_seen = 1'b1;
      end else if (lit_state.digit_seen || lit_state.point_seen) begin
        lit_state.rejected = 1'b1;
      end else begin
        lit_state.word_mode = 1'b1;
        match_inf(c);
      end
    end
    if (fin) begin
      has_verdict = 1'b1;
      if (lit_state.rejected)
        verdict = 1'b0;
      else if (lit_state.word_mode)
        verdict = !lit_state.word_mismatch && lit_state.word_matched == INF_LEN;
      else
        verdict = lit_state.digit_seen &&
                  (!lit_state.exponent_seen || lit_state.exponent_digit_seen);
      lit_state = NLV_STATE_RESET;
    end
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic logic [7:0] odd_char();
    logic [7:0] c;
    case ($urandom_range(0, 11))
      0:       c = CH_PLUS;
      1:       c = CH_MINUS;
      2:       c = CH_POINT;
      3:       c = CH_E_LO;
      4:       c = CH_E_UP;
      5:       c = CH_I;
      6:       c = CH_N;
      7:       c = CH_F;
      8:       c = CH_NUL;
      9:       c = 8'($urandom_range(8'h80, 8'hFF));
      default: c = CH_ZERO + 8'($urandom_range(0, 9));
    endcase
    return c;
  endfunction

  function automatic logic [7:0] sign_char();
    return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
  endfunction

  task automatic queue_string(input logic [7:0] text[$], input logic drain);
    for (int i = 0; i < text.size(); i++)
      char_feed.push_back('{ch: text[i], fin: (i == text.size() - 1), drain: (drain && i == 0)});
  endtask

  task automatic queue_literal(input string s);
    logic [7:0] text[$];
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    queue_string(text, 1'b0);
  endtask

  task automatic random_number(output logic [7:0] text[$]);
    int mant;
    int pt;
    text = {};
    repeat ($urandom_range(0, 2)) text.push_back(sign_char());
    mant = $urandom_range(0, 4);
    pt = $urandom_range(0, 2) == 0 ? -1 : $urandom_range(0, mant);
    for (int i = 0; i <= mant; i++) begin
      if (i == pt) text.push_back(CH_POINT);
      if (i < mant) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 1)) begin
      text.push_back($urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
      repeat ($urandom_range(0, 2)) text.push_back(sign_char());
      repeat ($urandom_range(0, 3)) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end
    if (text.size() == 0) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic random_inf(output logic [7:0] text[$]);
    text = {};
    repeat ($urandom_range(0, 2)) text.push_back(sign_char());
    text.push_back(CH_I);
    text.push_back(CH_N);
    text.push_back(CH_F);
    case ($urandom_range(0, 5))
      0: void'(text.pop_back());
      1: text.push_back(odd_char());
      2: text[$urandom_range(0, text.size() - 1)] = odd_char();
      default: ;
    endcase
  endtask

  initial begin
    logic [7:0] text[$];
    int strings;
    chars_ch.valid = 1'b0;
    chars_ch.byte_in = 8'h00;
    chars_ch.last = 1'b0;
    verdict_ch.ready = 1'b0;

    queue_literal("9");
    queue_literal("-inf");
    queue_literal(".5E+7");
    queue_literal("e");
    queue_string({8'hFF}, 1'b0);
    queue_string({CH_NUL}, 1'b0);
    queue_literal("in-");
    queue_literal("infs");
    queue_literal("1.2.");

    strings = 0;
    while (char_feed.size() < BYTE_TARGET) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
          random_number(text);
          if ($urandom_range(0, 3) == 0) text[$urandom_range(0, text.size() - 1)] = odd_char();
        end
        11, 12, 13, 14: random_inf(text);
        default: begin
          text = {};
          repeat ($urandom_range(1, 6))
            text.push_back($urandom_range(0, 1) ? odd_char() : 8'($urandom_range(0, 255)));
        end
      endcase
      queue_string(text, strings == 20 || strings == 90);
      strings++;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (char_feed.size() > 0) @(posedge clk);
    while (verdict_due.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && verdict_due.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------- driver
  int char_gap = 0;

  always @(posedge clk) begin
    logic offer;
    logic has_v;
    logic v;
    if (rst) begin
      chars_ch.valid <= 1'b0;
      chars_ch.byte_in <= 8'h00;
      chars_ch.last <= 1'b0;
      char_gap = 0;
    end else begin
      offer = 1'b0;
      if (chars_ch.valid && chars_ch.ready) begin
        scan_char(chars_ch.byte_in, chars_ch.last, has_v, v);
        if (has_v) verdict_due.push_back(v);
        void'(char_feed.pop_front());
      end else if (chars_ch.valid) begin
        offer = 1'b1;  // beat still pending, hold it
      end
      if (!offer && char_feed.size() > 0) begin
        if (char_gap > 0) begin
          char_gap--;
        end else if (char_feed.size() > QUIET_TAIL && $urandom_range(0, 24) == 0) begin
          char_gap = $urandom_range(0, 16);
        end else if (!(char_feed[0].drain && verdict_due.size() > 0)) begin
          offer = 1'b1;
        end
      end
      chars_ch.valid <= offer;
      if (offer) begin
        chars_ch.byte_in <= char_feed[0].ch;
        chars_ch.last <= char_feed[0].fin;
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  int   verdict_hold = 0;
  logic long_hold_done = 1'b0;

  always @(posedge clk) begin
    logic want;
    if (rst) begin
      verdict_ch.ready <= 1'b0;
      verdict_hold = 0;
    end else begin
      if (verdict_ch.valid && verdict_ch.ready) begin
        if (verdict_due.size() == 0) begin
          $display("%0t: unexpected verdict beat, expected none, actual %0b",
                   $time, verdict_ch.valid_res);
          mismatches++;
        end else begin
          want = verdict_due.pop_front();
          if (verdict_ch.valid_res !== want) begin
            $display("%0t: valid_res mismatch, expected %0b, actual %0b",
                     $time, want, verdict_ch.valid_res);
            mismatches++;
          end
        end
        verdicts_seen++;
      end
      if (verdict_hold == 0) begin
        if (verdicts_seen >= 30 && !long_hold_done) begin
          long_hold_done = 1'b1;
          verdict_hold = LONG_HOLD;
        end else if (char_feed.size() > QUIET_TAIL && $urandom_range(0, 15) == 0) begin
          verdict_hold = $urandom_range(1, 17);
        end
      end
      if (verdict_hold > 0) begin
        verdict_hold--;
        verdict_ch.ready <= 1'b0;
      end else begin
        verdict_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((chars_ch.valid && chars_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
